@@ sv/assert_macros.svh @@
// assertion macros shared by the checker files
// expects aclk and aresetn in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock outside reset
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/ipfr_pkg.sv @@
// shared constants, types and codes for the fragment reassembly tracker
// no dependencies
package ipfr_pkg;

    localparam int ENTRIES       = 16;
    localparam int GRANULE_BYTES = 8;
    localparam int WORD_BITS     = 64;
    localparam int SPAN_BYTES    = 65536;
    localparam int GRANULES      = SPAN_BYTES / GRANULE_BYTES;
    localparam int WORDS         = (GRANULES + WORD_BITS - 1) / WORD_BITS;

    localparam int E_W    = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int GI_W   = $clog2(GRANULES);
    localparam int G_W    = GI_W + 1;
    localparam int GOFF_W = $clog2(GRANULE_BYTES);
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int W_W    = $clog2(WORDS);
    localparam int ADDR_W = E_W + W_W;
    localparam int LEN_W  = 17;

    localparam int ID_W   = 16;
    localparam int OFF_W  = 16;
    localparam int HDR_W  = 6;
    localparam int LIM_W  = 5;
    localparam int STAT_W = 2;
    localparam int EV_W   = 5;
    localparam int TOT_W  = 16;

    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(16);

    typedef enum logic [STAT_W-1:0] {
        ST_PENDING = 2'd0,
        ST_DONE    = 2'd1,
        ST_REJECT  = 2'd2
    } status_t;

    typedef struct packed {
        logic [W_W-1:0]  word;
        logic [GI_W-1:0] lo;
        logic [GI_W-1:0] hi_last;
    } word_req_t;

    typedef struct packed {
        logic                 overlap;
        logic [WORD_BITS-1:0] merged;
        logic                 zero_found;
        logic [BIT_W-1:0]     zero_pos;
    } word_rsp_t;

endpackage

@@ sv/ipfr_bitmap_ram.sv @@
// coverage bitmap storage, one port, registered read
// depends on ipfr_pkg
module ipfr_bitmap_ram (
    input  logic                               aclk,
    input  logic                               en,
    input  logic                               we,
    input  logic [ipfr_pkg::ADDR_W-1:0]        addr,
    input  logic [ipfr_pkg::WORD_BITS-1:0]     wdata,
    output logic [ipfr_pkg::WORD_BITS-1:0]     rdata
);

    logic [ipfr_pkg::WORD_BITS-1:0] mem [ipfr_pkg::ENTRIES * ipfr_pkg::WORDS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else if (en) begin
            rdata <= mem[addr];
        end
    end

endmodule

@@ sv/ipfr_word_unit.sv @@
// shared bitmap word unit: range mask, overlap test, merge, first-zero search
// depends on ipfr_pkg
module ipfr_word_unit (
    input  ipfr_pkg::word_req_t             req,
    input  logic [ipfr_pkg::WORD_BITS-1:0]  rdata,
    output ipfr_pkg::word_rsp_t             rsp
);

    localparam int WB = ipfr_pkg::WORD_BITS;

    logic [ipfr_pkg::W_W-1:0]   lo_word;
    logic [ipfr_pkg::W_W-1:0]   hi_word;
    logic [ipfr_pkg::BIT_W-1:0] lo_bit;
    logic [ipfr_pkg::BIT_W-1:0] hi_bit;
    logic [WB-1:0]              mask_lo;
    logic [WB-1:0]              mask_hi;
    logic [WB-1:0]              mask;
    logic [WB-1:0]              fill;

    assign lo_word = req.lo[ipfr_pkg::GI_W-1:ipfr_pkg::BIT_W];
    assign lo_bit  = req.lo[ipfr_pkg::BIT_W-1:0];
    assign hi_word = req.hi_last[ipfr_pkg::GI_W-1:ipfr_pkg::BIT_W];
    assign hi_bit  = req.hi_last[ipfr_pkg::BIT_W-1:0];

    assign mask_lo = (req.word == lo_word) ? ({WB{1'b1}} << lo_bit) : {WB{1'b1}};
    assign mask_hi = (req.word == hi_word) ? ~(({WB{1'b1}} << hi_bit) << 1) : {WB{1'b1}};
    assign mask    = mask_lo & mask_hi;
    assign fill    = rdata | ~mask;

    always_comb begin
        rsp.overlap    = |(rdata & mask);
        rsp.merged     = rdata | mask;
        rsp.zero_found = ~&fill;
        rsp.zero_pos   = '0;
        for (int b = WB - 1; b >= 0; b--) begin
            if (!fill[b]) begin
                rsp.zero_pos = ipfr_pkg::BIT_W'(b);
            end
        end
    end

endmodule

@@ sv/ip_fragment_reassembly_tracker.sv @@
// a malformed fragment goes from accept straight to the result stage; otherwise lookup walks
// up to 16 entries one a cycle, eviction may repeat, a new packet clears its 128 bitmap
// words one a cycle, and the overlap, set and gap passes take a read state and a check or
// write state per bitmap word through the single ram port; an output stall holds the result
// throughput: one fragment at a time, next accepted after the result is registered
// reset: synchronous active-low aresetn clears entry valid bits and control state
module ip_fragment_reassembly_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // frag_ident, frag_offset, frag_length, header_length, mf_flag, pad
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // done_ident, assembled_len, evicted_count, pad
    output logic [39:0] m_tdata,
    // status
    output logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_LOOKUP   = 15'b000000000000010,
        S_CHECK    = 15'b000000000000100,
        S_OVL_RD   = 15'b000000000001000,
        S_OVL_CHK  = 15'b000000000010000,
        S_EVICT    = 15'b000000000100000,
        S_CLEAR    = 15'b000000001000000,
        S_SET_INIT = 15'b000000010000000,
        S_SET_RD   = 15'b000000100000000,
        S_SET_WR   = 15'b000001000000000,
        S_UPD      = 15'b000010000000000,
        S_GAP_RD   = 15'b000100000000000,
        S_GAP_CHK  = 15'b001000000000000,
        S_DONE     = 15'b010000000000000,
        S_FINISH   = 15'b100000000000000
    } state_t;

    localparam int NE = ipfr_pkg::ENTRIES;

    state_t state_reg, state_next;

    logic [ipfr_pkg::ID_W-1:0]   id_reg, id_next;
    logic [ipfr_pkg::GI_W-1:0]   g0_reg, g0_next;
    logic [ipfr_pkg::G_W-1:0]    g1_reg, g1_next;
    logic [ipfr_pkg::LEN_W-1:0]  end_reg, end_next;
    logic [ipfr_pkg::HDR_W-1:0]  hdr_reg, hdr_next;
    logic                        mf_reg, mf_next;
    logic                        off_zero_reg, off_zero_next;
    logic [ipfr_pkg::E_W-1:0]    idx_reg, idx_next;
    logic [ipfr_pkg::E_W-1:0]    ent_reg, ent_next;
    logic [ipfr_pkg::W_W-1:0]    w_reg, w_next;
    logic [ipfr_pkg::GI_W-1:0]   lo_reg, lo_next;
    logic [ipfr_pkg::GI_W-1:0]   hi_last_reg, hi_last_next;
    logic [ipfr_pkg::G_W-1:0]    gap_reg, gap_next;
    logic [ipfr_pkg::CNT_W-1:0]  ev_reg, ev_next;
    logic                        cur_gen_reg, cur_gen_next;
    logic [ipfr_pkg::LIM_W-1:0]  lim_reg;

    ipfr_pkg::status_t           res_status_reg, res_status_next;
    logic [ipfr_pkg::TOT_W-1:0]  res_total_reg, res_total_next;
    logic [ipfr_pkg::EV_W-1:0]   res_ev_reg, res_ev_next;

    logic                        m_valid_reg;
    ipfr_pkg::status_t           m_status_reg;
    logic [ipfr_pkg::ID_W-1:0]   m_ident_reg;
    logic [ipfr_pkg::TOT_W-1:0]  m_total_reg;
    logic [ipfr_pkg::EV_W-1:0]   m_ev_reg;

    logic [NE-1:0]               valid_reg;
    logic [NE-1:0]               gen_reg;
    logic [NE-1:0]               have_last_reg;
    logic [ipfr_pkg::ID_W-1:0]   ident_reg    [NE];
    logic [ipfr_pkg::LEN_W-1:0]  last_end_reg [NE];
    logic [ipfr_pkg::HDR_W-1:0]  first_hdr_reg[NE];
    logic [ipfr_pkg::LEN_W-1:0]  next_gap_reg [NE];

    logic alloc_wr, evict_wr, upd_wr, done_wr;
    logic ram_en, ram_we;
    logic [ipfr_pkg::WORD_BITS-1:0] ram_wdata, ram_rdata;

    ipfr_pkg::word_req_t wreq;
    ipfr_pkg::word_rsp_t wrsp;

    // input decode
    logic [ipfr_pkg::ID_W-1:0]   in_ident;
    logic [ipfr_pkg::OFF_W-1:0]  in_off, in_len;
    logic [ipfr_pkg::HDR_W-1:0]  in_hdr;
    logic                        in_mf;
    logic [ipfr_pkg::LEN_W-1:0]  in_end;
    logic [ipfr_pkg::LEN_W:0]    in_end_up;
    logic                        in_bad;

    assign in_ident  = s_tdata[15:0];
    assign in_off    = s_tdata[31:16];
    assign in_len    = s_tdata[47:32];
    assign in_hdr    = s_tdata[53:48];
    assign in_mf     = s_tdata[54];
    assign in_end    = ipfr_pkg::LEN_W'(in_off) + ipfr_pkg::LEN_W'(in_len);
    assign in_end_up = (ipfr_pkg::LEN_W + 1)'(in_end) + (ipfr_pkg::LEN_W + 1)'(ipfr_pkg::GRANULE_BYTES - 1);
    assign in_bad    = (|in_off[ipfr_pkg::GOFF_W-1:0])
                    || (in_end > ipfr_pkg::LEN_W'(ipfr_pkg::SPAN_BYTES))
                    || (in_mf && ((in_len == '0) || (|in_len[ipfr_pkg::GOFF_W-1:0])));

    // entry views
    logic                        hit;
    logic                        cur_have_last;
    logic [ipfr_pkg::LEN_W-1:0]  cur_last_end, cur_gap, ng_raw, ng;
    logic [ipfr_pkg::HDR_W-1:0]  cur_hdr;
    logic [ipfr_pkg::G_W-1:0]    gstart, g1_m1;
    logic [ipfr_pkg::LEN_W:0]    tot;
    logic                        complete;
    logic [ipfr_pkg::W_W-1:0]    hi_word;

    assign hit           = valid_reg[idx_reg] && (ident_reg[idx_reg] == id_reg);
    assign cur_have_last = have_last_reg[ent_reg];
    assign cur_last_end  = last_end_reg[ent_reg];
    assign cur_gap       = next_gap_reg[ent_reg];
    assign cur_hdr       = first_hdr_reg[ent_reg];
    assign gstart        = cur_gap[ipfr_pkg::LEN_W-1:ipfr_pkg::GOFF_W];
    assign g1_m1         = g1_reg - ipfr_pkg::G_W'(1);
    assign ng_raw        = {gap_reg, ipfr_pkg::GOFF_W'(0)};
    assign ng            = (cur_have_last && (ng_raw > cur_last_end)) ? cur_last_end : ng_raw;
    assign complete      = cur_have_last && (ng >= cur_last_end);
    assign tot           = (ipfr_pkg::LEN_W + 1)'(cur_hdr) + (ipfr_pkg::LEN_W + 1)'(cur_last_end);
    assign hi_word       = hi_last_reg[ipfr_pkg::GI_W-1:ipfr_pkg::BIT_W];

    // eviction and allocation views
    logic [NE-1:0]              old_mask;
    logic [ipfr_pkg::CNT_W-1:0] live_cnt, old_cnt;
    logic [ipfr_pkg::E_W-1:0]   free_idx;
    logic                       over_limit;

    assign old_mask = valid_reg & (gen_reg ^ {NE{cur_gen_reg}});

    always_comb begin
        live_cnt = '0;
        old_cnt  = '0;
        free_idx = '0;
        for (int i = 0; i < NE; i++) begin
            live_cnt = live_cnt + ipfr_pkg::CNT_W'(valid_reg[i]);
            old_cnt  = old_cnt + ipfr_pkg::CNT_W'(old_mask[i]);
        end
        for (int i = NE - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = ipfr_pkg::E_W'(i);
            end
        end
    end

    assign over_limit = (32'(live_cnt) > 32'(lim_reg)) || (live_cnt == ipfr_pkg::CNT_W'(NE));

    assign wreq.word    = w_reg;
    assign wreq.lo      = lo_reg;
    assign wreq.hi_last = hi_last_reg;

    ipfr_word_unit u_word (
        .req   (wreq),
        .rdata (ram_rdata),
        .rsp   (wrsp)
    );

    ipfr_bitmap_ram u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  ({ent_reg, w_reg}),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign ram_en    = (state_reg == S_OVL_RD) || (state_reg == S_SET_RD)
                    || (state_reg == S_GAP_RD);
    assign ram_we    = (state_reg == S_CLEAR) || (state_reg == S_SET_WR);
    assign ram_wdata = (state_reg == S_SET_WR) ? wrsp.merged : '0;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        id_next         = id_reg;
        g0_next         = g0_reg;
        g1_next         = g1_reg;
        end_next        = end_reg;
        hdr_next        = hdr_reg;
        mf_next         = mf_reg;
        off_zero_next   = off_zero_reg;
        idx_next        = idx_reg;
        ent_next        = ent_reg;
        w_next          = w_reg;
        lo_next         = lo_reg;
        hi_last_next    = hi_last_reg;
        gap_next        = gap_reg;
        ev_next         = ev_reg;
        cur_gen_next    = cur_gen_reg;
        res_status_next = res_status_reg;
        res_total_next  = res_total_reg;
        res_ev_next     = res_ev_reg;
        alloc_wr        = 1'b0;
        evict_wr        = 1'b0;
        upd_wr          = 1'b0;
        done_wr         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    id_next        = in_ident;
                    g0_next        = in_off[ipfr_pkg::OFF_W-1:ipfr_pkg::GOFF_W];
                    g1_next        = in_end_up[ipfr_pkg::G_W+ipfr_pkg::GOFF_W-1:ipfr_pkg::GOFF_W];
                    end_next       = in_end;
                    hdr_next       = in_hdr;
                    mf_next        = in_mf;
                    off_zero_next  = (in_off == '0);
                    idx_next       = '0;
                    ev_next        = '0;
                    res_status_next = ipfr_pkg::ST_REJECT;
                    res_total_next = '0;
                    res_ev_next    = '0;
                    state_next     = in_bad ? S_FINISH : S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (hit) begin
                    ent_next   = idx_reg;
                    state_next = S_CHECK;
                end else if (idx_reg == ipfr_pkg::E_W'(NE - 1)) begin
                    state_next = S_EVICT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_CHECK: begin
                if (cur_have_last && ((end_reg > cur_last_end) || !mf_reg)) begin
                    state_next = S_FINISH;
                end else begin
                    lo_next      = g0_reg;
                    hi_last_next = mf_reg ? g1_m1[ipfr_pkg::GI_W-1:0]
                                          : ipfr_pkg::GI_W'(ipfr_pkg::GRANULES - 1);
                    w_next       = g0_reg[ipfr_pkg::GI_W-1:ipfr_pkg::BIT_W];
                    state_next   = S_OVL_RD;
                end
            end
            S_OVL_RD: begin
                state_next = S_OVL_CHK;
            end
            S_OVL_CHK: begin
                if (wrsp.overlap) begin
                    state_next = S_FINISH;
                end else if (w_reg == hi_word) begin
                    state_next = S_SET_INIT;
                end else begin
                    w_next     = w_reg + 1'b1;
                    state_next = S_OVL_RD;
                end
            end
            S_EVICT: begin
                if (over_limit) begin
                    evict_wr     = 1'b1;
                    ev_next      = ev_reg + old_cnt;
                    cur_gen_next = ~cur_gen_reg;
                end else begin
                    alloc_wr   = 1'b1;
                    ent_next   = free_idx;
                    w_next     = '0;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (w_reg == ipfr_pkg::W_W'(ipfr_pkg::WORDS - 1)) begin
                    state_next = S_SET_INIT;
                end else begin
                    w_next = w_reg + 1'b1;
                end
            end
            S_SET_INIT: begin
                if (g1_reg > ipfr_pkg::G_W'(g0_reg)) begin
                    lo_next      = g0_reg;
                    hi_last_next = g1_m1[ipfr_pkg::GI_W-1:0];
                    w_next       = g0_reg[ipfr_pkg::GI_W-1:ipfr_pkg::BIT_W];
                    state_next   = S_SET_RD;
                end else begin
                    state_next = S_UPD;
                end
            end
            S_SET_RD: begin
                state_next = S_SET_WR;
            end
            S_SET_WR: begin
                if (w_reg == hi_word) begin
                    state_next = S_UPD;
                end else begin
                    w_next     = w_reg + 1'b1;
                    state_next = S_SET_RD;
                end
            end
            S_UPD: begin
                upd_wr = 1'b1;
                if (gstart >= ipfr_pkg::G_W'(ipfr_pkg::GRANULES)) begin
                    gap_next   = ipfr_pkg::G_W'(ipfr_pkg::GRANULES);
                    state_next = S_DONE;
                end else begin
                    lo_next      = gstart[ipfr_pkg::GI_W-1:0];
                    hi_last_next = ipfr_pkg::GI_W'(ipfr_pkg::GRANULES - 1);
                    w_next       = gstart[ipfr_pkg::GI_W-1:ipfr_pkg::BIT_W];
                    state_next   = S_GAP_RD;
                end
            end
            S_GAP_RD: begin
                state_next = S_GAP_CHK;
            end
            S_GAP_CHK: begin
                if (wrsp.zero_found) begin
                    gap_next   = ipfr_pkg::G_W'({w_reg, wrsp.zero_pos});
                    state_next = S_DONE;
                end else if (w_reg == ipfr_pkg::W_W'(ipfr_pkg::WORDS - 1)) begin
                    gap_next   = ipfr_pkg::G_W'(ipfr_pkg::GRANULES);
                    state_next = S_DONE;
                end else begin
                    w_next     = w_reg + 1'b1;
                    state_next = S_GAP_RD;
                end
            end
            S_DONE: begin
                done_wr     = 1'b1;
                res_ev_next = (32'(ev_reg) > 31) ? ipfr_pkg::EV_W'(31)
                                                 : ipfr_pkg::EV_W'(ev_reg);
                if (complete) begin
                    res_status_next = ipfr_pkg::ST_DONE;
                    res_total_next  = (tot > (ipfr_pkg::LEN_W + 1)'(65535))
                                    ? {ipfr_pkg::TOT_W{1'b1}} : tot[ipfr_pkg::TOT_W-1:0];
                end else begin
                    res_status_next = ipfr_pkg::ST_PENDING;
                    res_total_next  = '0;
                end
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cur_gen_reg <= 1'b0;
            lim_reg     <= ipfr_pkg::LIM_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_gen_reg <= cur_gen_next;
            if (cfg_we) begin
                lim_reg <= cfg_wdata;
            end
            if ((state_reg == S_FINISH) && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        id_reg         <= id_next;
        g0_reg         <= g0_next;
        g1_reg         <= g1_next;
        end_reg        <= end_next;
        hdr_reg        <= hdr_next;
        mf_reg         <= mf_next;
        off_zero_reg   <= off_zero_next;
        idx_reg        <= idx_next;
        ent_reg        <= ent_next;
        w_reg          <= w_next;
        lo_reg         <= lo_next;
        hi_last_reg    <= hi_last_next;
        gap_reg        <= gap_next;
        ev_reg         <= ev_next;
        res_status_reg <= res_status_next;
        res_total_reg  <= res_total_next;
        res_ev_reg     <= res_ev_next;
        if ((state_reg == S_FINISH) && (!m_valid_reg || m_tready)) begin
            m_status_reg <= res_status_reg;
            m_ident_reg  <= id_reg;
            m_total_reg  <= res_total_reg;
            m_ev_reg     <= res_ev_reg;
        end
    end

    // entry control bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            gen_reg       <= '0;
            have_last_reg <= '0;
        end else begin
            if (evict_wr) begin
                valid_reg <= valid_reg & ~old_mask;
            end
            if (alloc_wr) begin
                valid_reg[free_idx]     <= 1'b1;
                gen_reg[free_idx]       <= cur_gen_reg;
                have_last_reg[free_idx] <= 1'b0;
            end
            if (upd_wr && !mf_reg) begin
                have_last_reg[ent_reg] <= 1'b1;
            end
            if (done_wr && complete) begin
                valid_reg[ent_reg] <= 1'b0;
            end
        end
    end

    // entry payload
    always_ff @(posedge aclk) begin
        if (alloc_wr) begin
            ident_reg[free_idx]     <= id_reg;
            last_end_reg[free_idx]  <= '0;
            first_hdr_reg[free_idx] <= '0;
            next_gap_reg[free_idx]  <= '0;
        end
        if (upd_wr) begin
            if (off_zero_reg) begin
                first_hdr_reg[ent_reg] <= hdr_reg;
            end
            if (!mf_reg) begin
                last_end_reg[ent_reg] <= end_reg;
            end
        end
        if (done_wr) begin
            next_gap_reg[ent_reg] <= ng;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_ev_reg, m_total_reg, m_ident_reg};

endmodule

@@ sv/ipfr_checker.sv @@
// port-level checks for the fragment reassembly tracker, bound to the top level
// depends on ipfr_pkg and assert_macros.svh
`include "assert_macros.svh"

module ipfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // stalled result transaction stays offered
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // block is busy right after taking a fragment
    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // total length only on completion
    `ASSERT_IMPLIES(a_total_only_done, m_tvalid && (m_tuser != ipfr_pkg::ST_DONE),
                    m_tdata[31:16] == 16'd0)

    // rejection never evicts
    `ASSERT_IMPLIES(a_reject_no_evict, m_tvalid && (m_tuser == ipfr_pkg::ST_REJECT),
                    m_tdata[36:32] == 5'd0)

endmodule

bind ip_fragment_reassembly_tracker ipfr_checker u_ipfr_checker (.*);
